>>> hdl/a32c_pkg.sv
// Shared types and constants for the 16-lane Adler-32 checksum engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package a32c_pkg;

    localparam int MAX_BYTES = 16;
    localparam int DEF_BYTES = 16;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 5;
    localparam int PROD_W  = 13;
    localparam int SUM_W   = 12;
    localparam int WSUM_W  = 16;
    localparam int ACC_W   = 16;
    localparam int WIDE_W  = 21;
    localparam int RED_W   = 17;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 32;

    localparam logic [RED_W-1:0] ADLER_MOD   = 17'd65521;
    localparam logic [ACC_W-1:0] ADLER_START = 16'd1;
    // 2^16 mod 65521
    localparam logic [RED_W-1:0] FOLD_K      = 17'd15;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [CNT_W-1:0] cnt;
    } t_ctl;

endpackage

`default_nettype wire

>>> hdl/a32c_lane.sv
// One byte lane: masks its byte against the word count and forms its weighted term.
// Depends on a32c_pkg.
`default_nettype none

module a32c_lane #(
    parameter int LANE_IDX = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [a32c_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [a32c_pkg::CNT_W-1:0]    i_cnt,
    output logic      [a32c_pkg::BYTE_W-1:0]   o_byte,
    output logic      [a32c_pkg::PROD_W-1:0]   o_prod
);
    import a32c_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(LANE_IDX);

    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [CNT_W-1:0]  w_weight;

    always_comb begin
        w_weight = i_cnt - IDX;
        if (i_cnt > IDX) begin
            n_byte = i_byte;
            n_prod = PROD_W'(w_weight) * PROD_W'(i_byte);
        end else begin
            n_byte = '0;
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= n_byte;
            r_prod <= n_prod;
        end
    end

    assign o_byte = r_byte;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> hdl/a32c_merge.sv
// Two-level registered adder tree combining the lane bytes and weighted terms.
// Depends on a32c_pkg.
`default_nettype none

module a32c_merge #(
    parameter int LANES = a32c_pkg::DEF_BYTES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire a32c_pkg::t_ctl                i_ctl,
    input  wire logic [a32c_pkg::BYTE_W-1:0]   i_byte [LANES],
    input  wire logic [a32c_pkg::PROD_W-1:0]   i_prod [LANES],
    output a32c_pkg::t_ctl                     o_ctl,
    output logic      [a32c_pkg::SUM_W-1:0]    o_sum,
    output logic      [a32c_pkg::WSUM_W-1:0]   o_wsum
);
    import a32c_pkg::*;

    localparam int GROUPS = (LANES + 3) / 4;

    t_ctl              r_ctl1, r_ctl2;
    logic [SUM_W-1:0]  r_gsum  [GROUPS];
    logic [WSUM_W-1:0] r_gwsum [GROUPS];
    logic [SUM_W-1:0]  n_gsum  [GROUPS];
    logic [WSUM_W-1:0] n_gwsum [GROUPS];
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic [WSUM_W-1:0] r_wsum, n_wsum;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_gsum[g]  = '0;
            n_gwsum[g] = '0;
            for (int k = 0; k < 4; k++) begin
                if (g * 4 + k < LANES) begin
                    n_gsum[g]  = n_gsum[g]  + SUM_W'(i_byte[g * 4 + k]);
                    n_gwsum[g] = n_gwsum[g] + WSUM_W'(i_prod[g * 4 + k]);
                end
            end
        end
    end

    always_comb begin
        n_sum  = '0;
        n_wsum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_sum  = n_sum  + r_gsum[g];
            n_wsum = n_wsum + r_gwsum[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gsum  <= n_gsum;
            r_gwsum <= n_gwsum;
            r_sum   <= n_sum;
            r_wsum  <= n_wsum;
        end
    end

    assign o_ctl  = r_ctl2;
    assign o_sum  = r_sum;
    assign o_wsum = r_wsum;

endmodule

`default_nettype wire

>>> hdl/a32c_accum.sv
// Running Adler-32 sums with modular reduction, plus the checksum output register.
// Depends on a32c_pkg.
`default_nettype none

module a32c_accum (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_take,
    input  wire a32c_pkg::t_ctl                i_ctl,
    input  wire logic [a32c_pkg::SUM_W-1:0]    i_sum,
    input  wire logic [a32c_pkg::WSUM_W-1:0]   i_wsum,
    output logic                               o_valid,
    output logic      [a32c_pkg::OUT_DATA_W-1:0] o_checksum,
    output logic      [a32c_pkg::ACC_W-1:0]    o_byte_sum
);
    import a32c_pkg::*;

    logic [ACC_W-1:0]      r_a, n_a;
    logic [ACC_W-1:0]      r_b, n_b;
    logic                  r_out_vld, n_out_vld;
    logic [OUT_DATA_W-1:0] r_cksum;

    logic [RED_W-1:0]  w_a_raw;
    logic [WIDE_W-1:0] w_mul;
    logic [WIDE_W-1:0] w_b_raw;
    logic [RED_W-1:0]  w_fold;
    logic [ACC_W-1:0]  w_a_new, w_b_new;
    logic              w_step;

    always_comb begin
        w_a_raw = RED_W'(r_a) + RED_W'(i_sum);
        w_a_new = (w_a_raw >= ADLER_MOD) ? ACC_W'(w_a_raw - ADLER_MOD) : ACC_W'(w_a_raw);
        w_mul   = WIDE_W'(i_ctl.cnt) * WIDE_W'(r_a);
        w_b_raw = WIDE_W'(r_b) + w_mul + WIDE_W'(i_wsum);
        // fold bits above 16 back in via 2^16 = 15 (mod 65521)
        w_fold  = RED_W'(w_b_raw[WIDE_W-1:ACC_W]) * FOLD_K + RED_W'(w_b_raw[ACC_W-1:0]);
        w_b_new = (w_fold >= ADLER_MOD) ? ACC_W'(w_fold - ADLER_MOD) : ACC_W'(w_fold);
        w_step  = i_en && i_ctl.vld;
    end

    always_comb begin
        n_a       = r_a;
        n_b       = r_b;
        n_out_vld = r_out_vld && !i_take;
        if (w_step) begin
            if (i_ctl.last) begin
                n_a       = ADLER_START;
                n_b       = '0;
                n_out_vld = 1'b1;
            end else begin
                n_a = w_a_new;
                n_b = w_b_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= ADLER_START;
            r_b       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_a       <= n_a;
            r_b       <= n_b;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && i_ctl.last) begin
            r_cksum <= {w_b_new, w_a_new};
        end
    end

    assign o_valid    = r_out_vld;
    assign o_checksum = r_cksum;
    assign o_byte_sum = r_a;

endmodule

`default_nettype wire

>>> hdl/adler32_checksum_16_lane_top.sv
// Adler-32 checksum engine, top level: byte lanes, merge tree, accumulator.
// Depends on a32c_pkg, a32c_lane, a32c_merge, a32c_accum.
//
// Takes one word of up to BYTES_PER_ITEM bytes every cycle; byte_count above
// BYTES_PER_ITEM is clamped. A word with tlast set yields one checksum word,
// {weighted sum, byte sum}, once it has passed the lane register, the two adder
// tree levels and the checksum output register, and the sums then restart at
// 1 and 0. The accumulator's update of the running sums sets the rate of one
// word per cycle. Input is held off only while a finished checksum waits
// unread and another final word has reached the accumulator.
`default_nettype none

module adler32_checksum_16_lane_top #(
    parameter int BYTES_PER_ITEM = a32c_pkg::DEF_BYTES
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [63:0] bytes_low, [127:64] bytes_high, [132:128] byte_count, rest zero
    input  wire logic [a32c_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // end_of_message
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [31:0] checksum
    output logic      [a32c_pkg::OUT_DATA_W-1:0]    o_m_tdata
);
    import a32c_pkg::*;

    localparam logic [CNT_W-1:0] LANE_MAX = CNT_W'(BYTES_PER_ITEM);

    logic [2*64-1:0]    w_bytes;
    logic [CNT_W-1:0]   w_cnt_in, w_cnt;
    logic               w_adv;
    t_ctl               w_ctl_in, r_ctl1, w_mctl;
    logic [BYTE_W-1:0]  w_lbyte [BYTES_PER_ITEM];
    logic [PROD_W-1:0]  w_lprod [BYTES_PER_ITEM];
    logic [SUM_W-1:0]   w_sum;
    logic [WSUM_W-1:0]  w_wsum;
    logic [ACC_W-1:0]   w_byte_sum;

    assign w_bytes  = i_s_tdata[127:0];
    assign w_cnt_in = i_s_tdata[132:128];
    assign w_cnt    = (w_cnt_in > LANE_MAX) ? LANE_MAX : w_cnt_in;

    assign w_adv      = !(w_mctl.vld && w_mctl.last && o_m_tvalid && !i_m_tready);
    assign o_s_tready = w_adv;

    always_comb begin
        w_ctl_in.vld  = i_s_tvalid;
        w_ctl_in.last = i_s_tlast;
        w_ctl_in.cnt  = w_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (w_adv) begin
            r_ctl1 <= w_ctl_in;
        end
    end

    for (genvar l = 0; l < BYTES_PER_ITEM; l++) begin : g_lane
        a32c_lane #(
            .LANE_IDX (l)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_byte (w_bytes[l*BYTE_W +: BYTE_W]),
            .i_cnt  (w_cnt),
            .o_byte (w_lbyte[l]),
            .o_prod (w_lprod[l])
        );
    end

    a32c_merge #(
        .LANES (BYTES_PER_ITEM)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_ctl   (r_ctl1),
        .i_byte  (w_lbyte),
        .i_prod  (w_lprod),
        .o_ctl   (w_mctl),
        .o_sum   (w_sum),
        .o_wsum  (w_wsum)
    );

    a32c_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_take     (i_m_tready),
        .i_ctl      (w_mctl),
        .i_sum      (w_sum),
        .i_wsum     (w_wsum),
        .o_valid    (o_m_tvalid),
        .o_checksum (o_m_tdata),
        .o_byte_sum (w_byte_sum)
    );

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");

    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (RED_W'(o_m_tdata[15:0]) < ADLER_MOD)
                    && (RED_W'(o_m_tdata[31:16]) < ADLER_MOD))
        else $error("checksum half not reduced mod 65521");

    a_state_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RED_W'(w_byte_sum) < ADLER_MOD)
        else $error("running byte sum out of range");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_mctl.vld && w_mctl.last && w_adv))
        else $error("checksum word without a final word");

endmodule

`default_nettype wire
